>>> rtl/cau_pkg.sv
// Shared operation codes for the complex arithmetic unit.
`default_nettype none
package cau_pkg;
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;
endpackage
`default_nettype wire

>>> rtl/cau_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module cau_div #(
    parameter int NW = 34,
    parameter int DW = 33,
    parameter int QW = 24
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic [QW-1:0]      quo
);
    // quotient = num / den, QW bits; caller checks num[NW-1:QW] < den
    logic [DW:0]   rem_reg  [QW+1];
    logic [NW-1:0] num_reg  [QW+1];
    logic [DW-1:0] den_reg  [QW+1];
    logic [QW-1:0] q_reg    [QW+1];
    logic [QW:0]   v_reg;

    always_comb
    begin
        // seed the remainder with the bits above the quotient window
        rem_reg[0] = (DW+1)'(num[NW-1:QW]);
        num_reg[0] = num;
        den_reg[0] = den;
        q_reg[0]   = '0;
        v_reg[0]   = in_valid;
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW+1:0] trial;
        always_comb
        begin
            trial = {rem_reg[s], num_reg[s][QW-1-s]} - {2'b00, den_reg[s]};
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else
                v_reg[s+1] <= v_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (v_reg[s])
            begin
                num_reg[s+1] <= num_reg[s];
                den_reg[s+1] <= den_reg[s];
                if (!trial[DW+1])
                begin
                    rem_reg[s+1] <= trial[DW:0];
                    q_reg[s+1]   <= {q_reg[s][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= {rem_reg[s][DW-1:0], num_reg[s][QW-1-s]};
                    q_reg[s+1]   <= {q_reg[s][QW-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = q_reg[QW];
endmodule
`default_nettype wire

>>> rtl/complex_arithmetic_unit_top.sv
// Top level of the complex arithmetic unit.
// Accepts one item per cycle (busy stays low) and returns each result with
// done high once the item has passed the three operand, product and combine
// stages, then the bit-per-stage divider of DATA_WIDTH + FRAC_BITS + 1
// stages, then the output register. Add, subtract and multiply travel
// through a delay line so every mode has the same latency and results leave
// in order. The receiver cannot stall the unit.
`default_nettype none
module complex_arithmetic_unit_top #(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   mode,
    input  wire logic signed [DATA_WIDTH-1:0] a_real,
    input  wire logic signed [DATA_WIDTH-1:0] a_imag,
    input  wire logic signed [DATA_WIDTH-1:0] b_real,
    input  wire logic signed [DATA_WIDTH-1:0] b_imag,
    output logic                              done,
    output logic signed [DATA_WIDTH-1:0]      res_real,
    output logic signed [DATA_WIDTH-1:0]      res_imag,
    output logic                              overflow,
    output logic                              divide_by_zero
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;          // one product
    localparam int SW = 2 * W + 1;      // sum of two products
    localparam int QW = W + FRAC_BITS + 1; // enough to detect saturation
    localparam int NW = SW + FRAC_BITS;
    localparam int DL = QW;             // divider depth
    localparam logic [QW:0] MAXP = (QW+1)'(1) << (W - 1);

    typedef struct packed {
        logic                 neg;
        logic [QW:0]          mag;
    } sm_t;

    // stage 1: register operands
    logic          v1_reg;
    logic [1:0]    m1_reg;
    logic signed [W-1:0] a1_reg, b1_reg, c1_reg, d1_reg;
    // stage 2: six products and the add/subtract sums
    logic          v2_reg;
    logic [1:0]    m2_reg;
    logic signed [PW-1:0] ac_reg, bd_reg, bc_reg, ad_reg, cc_reg, dd_reg;
    logic signed [W:0] s_re_reg, s_im_reg;
    // stage 3: combine
    logic          v3_reg;
    logic [1:0]    m3_reg;
    logic signed [SW:0] re3_reg, im3_reg;
    logic [SW-1:0] den3_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg <= mode;
        a1_reg <= a_real;
        b1_reg <= a_imag;
        c1_reg <= b_real;
        d1_reg <= b_imag;
        m2_reg <= m1_reg;
        ac_reg <= a1_reg * c1_reg;
        bd_reg <= b1_reg * d1_reg;
        bc_reg <= b1_reg * c1_reg;
        ad_reg <= a1_reg * d1_reg;
        cc_reg <= c1_reg * c1_reg;
        dd_reg <= d1_reg * d1_reg;
        if (m1_reg == OP_ADD)
        begin
            s_re_reg <= (W+1)'(a1_reg) + (W+1)'(c1_reg);
            s_im_reg <= (W+1)'(b1_reg) + (W+1)'(d1_reg);
        end
        else
        begin
            s_re_reg <= (W+1)'(a1_reg) - (W+1)'(c1_reg);
            s_im_reg <= (W+1)'(b1_reg) - (W+1)'(d1_reg);
        end
        m3_reg <= m2_reg;
        den3_reg <= SW'($unsigned(cc_reg)) + SW'($unsigned(dd_reg));
        case (m2_reg)
            OP_MUL:
            begin
                re3_reg <= (SW+1)'(ac_reg) - (SW+1)'(bd_reg);
                im3_reg <= (SW+1)'(bc_reg) + (SW+1)'(ad_reg);
            end
            OP_DIV:
            begin
                re3_reg <= (SW+1)'(ac_reg) + (SW+1)'(bd_reg);
                im3_reg <= (SW+1)'(bc_reg) - (SW+1)'(ad_reg);
            end
            default:
            begin
                re3_reg <= (SW+1)'(s_re_reg);
                im3_reg <= (SW+1)'(s_im_reg);
            end
        endcase
    end

    // magnitudes and divider operands
    logic [SW:0] re_mag, im_mag;
    logic [NW-1:0] re_num, im_num;
    assign re_mag = re3_reg[SW] ? (SW+1)'(-re3_reg) : $unsigned(re3_reg);
    assign im_mag = im3_reg[SW] ? (SW+1)'(-im3_reg) : $unsigned(im3_reg);
    // magnitudes are below 2^(2W-1)+1, fit in SW bits
    assign re_num = {re_mag[SW-1:0], {FRAC_BITS{1'b0}}};
    assign im_num = {im_mag[SW-1:0], {FRAC_BITS{1'b0}}};

    // divider yields low QW bits; prefixed high bits flag saturation
    logic [NW-1:0] re_num_lo, im_num_lo;
    logic re_big, im_big;
    assign re_big = (re_num >> QW) >= NW'(den3_reg);
    assign im_big = (im_num >> QW) >= NW'(den3_reg);
    assign re_num_lo = re_num;
    assign im_num_lo = im_num;

    logic [QW-1:0] re_q, im_q;
    cau_div #(.NW(NW), .DW(SW), .QW(QW)) u_div_re (
        .clk(clk), .rst_n(rst_n), .in_valid(v3_reg),
        .num(re_num_lo), .den(den3_reg), .quo(re_q));
    cau_div #(.NW(NW), .DW(SW), .QW(QW)) u_div_im (
        .clk(clk), .rst_n(rst_n), .in_valid(v3_reg),
        .num(im_num_lo), .den(den3_reg), .quo(im_q));

    // delay line for side information
    typedef struct packed {
        logic [1:0]    m;
        logic          dz;
        logic          rbig;
        logic          ibig;
        sm_t           r;
        sm_t           i;
    } side_t;

    side_t side_in;
    side_t side_reg [DL+1];
    logic [DL:0] sv_reg;

    always_comb
    begin
        side_in.m    = m3_reg;
        side_in.dz   = (m3_reg == OP_DIV) && (den3_reg == '0);
        side_in.rbig = re_big;
        side_in.ibig = im_big;
        side_in.r.neg = re3_reg[SW];
        side_in.i.neg = im3_reg[SW];
        if (m3_reg == OP_MUL)
        begin
            side_in.r.mag = (QW+1)'(re_mag >> FRAC_BITS);
            side_in.i.mag = (QW+1)'(im_mag >> FRAC_BITS);
            if ((re_mag >> FRAC_BITS) > (SW+1)'(MAXP))
                side_in.r.mag = MAXP + 1'b1;
            if ((im_mag >> FRAC_BITS) > (SW+1)'(MAXP))
                side_in.i.mag = MAXP + 1'b1;
        end
        else
        begin
            side_in.r.mag = (QW+1)'(re_mag);
            side_in.i.mag = (QW+1)'(im_mag);
        end
        side_reg[0] = side_in;
        sv_reg[0]   = v3_reg;
    end

    for (genvar k = 0; k < DL; k++) begin : g_dly
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[k+1] <= 1'b0;
            else
                sv_reg[k+1] <= sv_reg[k];
        end
        always_ff @(posedge clk)
        begin
            side_reg[k+1] <= side_reg[k];
        end
    end

    // final selection and saturation
    side_t sd;
    sm_t r_sm, i_sm;
    logic r_ov, i_ov;
    logic signed [W-1:0] r_v, i_v;
    logic done_reg, ovf_reg, dz_reg;
    logic signed [W-1:0] rr_reg, ri_reg;

    function automatic logic signed [W-1:0] sat(input sm_t x, output logic ov);
        ov = 1'b0;
        if (!x.neg && x.mag > MAXP - 1'b1)
        begin
            ov = 1'b1;
            sat = {1'b0, {(W-1){1'b1}}};
        end
        else if (x.neg && x.mag > MAXP)
        begin
            ov = 1'b1;
            sat = {1'b1, {(W-1){1'b0}}};
        end
        else if (x.neg)
            sat = W'(-x.mag);
        else
            sat = W'(x.mag);
    endfunction

    always_comb
    begin
        sd   = side_reg[DL];
        r_sm = sd.r;
        i_sm = sd.i;
        if (sd.m == OP_DIV)
        begin
            r_sm.mag = sd.rbig ? {(QW+1){1'b1}} : {1'b0, re_q};
            i_sm.mag = sd.ibig ? {(QW+1){1'b1}} : {1'b0, im_q};
        end
        r_v = sat(r_sm, r_ov);
        i_v = sat(i_sm, i_ov);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sv_reg[DL];
    end

    always_ff @(posedge clk)
    begin
        if (sd.dz)
        begin
            rr_reg  <= '0;
            ri_reg  <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            rr_reg  <= r_v;
            ri_reg  <= i_v;
            ovf_reg <= r_ov | i_ov;
        end
        dz_reg <= sd.dz;
    end

    assign done           = done_reg;
    assign res_real       = rr_reg;
    assign res_imag       = ri_reg;
    assign overflow       = ovf_reg;
    assign divide_by_zero = dz_reg;
endmodule
`default_nettype wire

>>> test/complex_arithmetic_unit_top_tb.sv
// Self-checking testbench for the complex arithmetic unit: directed table, then random items.
module complex_arithmetic_unit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    localparam int FRAC = 8;
    localparam int DW = 16;
    localparam int LAT = 3 + 2 * DW + FRAC + 16;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 ovf;
        logic                 dz;
    } cres_t;

    typedef struct {
        op_t                  op;
        logic signed [DW-1:0] ar, ai, br, bi;
        bit                   has_exp;
        cres_t                exp_res;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] mode = '0;
    logic signed [DW-1:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
    logic done;
    logic signed [DW-1:0] res_real, res_imag;
    logic overflow, divide_by_zero;

    cres_t pending_q[$];
    int errors = 0;

    complex_arithmetic_unit_top #(.FRAC_BITS(FRAC), .DATA_WIDTH(DW)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
        .done(done), .res_real(res_real), .res_imag(res_imag),
        .overflow(overflow), .divide_by_zero(divide_by_zero)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("FAIL complex_arithmetic_unit_top");
        $finish;
    end

    function automatic logic signed [DW-1:0] clamp(input bit neg, input longint unsigned mag,
                                                  inout logic ovf);
        longint unsigned half;
        half = 64'd1 << (DW - 1);
        if (!neg)
        begin
            if (mag > half - 1)
            begin
                ovf = 1'b1;
                return half - 1;
            end
            return mag;
        end
        if (mag > half)
        begin
            ovf = 1'b1;
            return -half;
        end
        return -mag;
    endfunction

    function automatic longint unsigned absval(input longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic logic signed [DW-1:0] fix_quotient(input longint num,
                                                         input longint unsigned den,
                                                         inout logic ovf);
        longint unsigned n, q, r, frac;
        n = absval(num);
        q = n / den;
        r = n % den;
        frac = 0;
        if (q >= (64'd1 << DW))
            return clamp(num < 0, 64'hFFFF_FFFF_FFFF_FFFF, ovf);
        for (int i = 0; i < FRAC; i++)
        begin
            r = r << 1;
            frac = frac << 1;
            if (r >= den)
            begin
                r -= den;
                frac |= 1;
            end
        end
        return clamp(num < 0, (q << FRAC) | frac, ovf);
    endfunction

    function automatic cres_t complex_result(input op_t op, input longint a, input longint b,
                                             input longint c, input longint d);
        cres_t r;
        longint unsigned den;
        r = '0;
        case (op)
            OP_ADD:
            begin
                r.re = clamp(a + c < 0, absval(a + c), r.ovf);
                r.im = clamp(b + d < 0, absval(b + d), r.ovf);
            end
            OP_SUB:
            begin
                r.re = clamp(a - c < 0, absval(a - c), r.ovf);
                r.im = clamp(b - d < 0, absval(b - d), r.ovf);
            end
            OP_MUL:
            begin
                r.re = clamp(a * c - b * d < 0, absval(a * c - b * d) >> FRAC, r.ovf);
                r.im = clamp(b * c + a * d < 0, absval(b * c + a * d) >> FRAC, r.ovf);
            end
            default:
            begin
                den = c * c + d * d;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    r.re = fix_quotient(a * c + b * d, den, r.ovf);
                    r.im = fix_quotient(b * c - a * d, den, r.ovf);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        cres_t e;
        if (done)
        begin
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result re=%h im=%h", $time, res_real, res_imag);
            end
            else
            begin
                e = pending_q.pop_front();
                if (res_real !== e.re)
                begin
                    errors++;
                    $display("%0t: res_real exp %h got %h", $time, e.re, res_real);
                end
                if (res_imag !== e.im)
                begin
                    errors++;
                    $display("%0t: res_imag exp %h got %h", $time, e.im, res_imag);
                end
                if (overflow !== e.ovf)
                begin
                    errors++;
                    $display("%0t: overflow exp %b got %b", $time, e.ovf, overflow);
                end
                if (divide_by_zero !== e.dz)
                begin
                    errors++;
                    $display("%0t: divide_by_zero exp %b got %b", $time, e.dz, divide_by_zero);
                end
            end
        end
    end

    // Hold one item on the ports until it is taken; drop start only for a gap.
    task automatic send_item(input vec_t v, input bit allow_gap);
        cres_t p;
        if (allow_gap && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start <= 1'b1;
        mode <= v.op;
        a_real <= v.ar;
        a_imag <= v.ai;
        b_real <= v.br;
        b_imag <= v.bi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = complex_result(v.op, v.ar, v.ai, v.br, v.bi);
        if (v.has_exp && p !== v.exp_res)
        begin
            errors++;
            $display("%0t: table row exp %h model %h", $time, v.exp_res, p);
        end
        pending_q.push_back(p);
    endtask

    function automatic vec_t row(op_t op, int ar, int ai, int br, int bi,
                                 bit has_exp = 0, cres_t e = '0);
        vec_t v;
        v.op = op;
        v.ar = ar;
        v.ai = ai;
        v.br = br;
        v.bi = bi;
        v.has_exp = has_exp;
        v.exp_res = e;
        return v;
    endfunction

    function automatic logic signed [DW-1:0] rand_part();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return $urandom_range(0, 1023) - 512;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        vec_t table_rows[$];
        vec_t v;
        int rounds;
        table_rows.push_back(row(OP_ADD, 0, 0, 0, 0, 1, '{0, 0, 0, 0}));
        table_rows.push_back(row(OP_ADD, 32767, 32767, 1, 1, 1, '{16'sh7FFF, 16'sh7FFF, 1, 0}));
        table_rows.push_back(row(OP_ADD, -32768, -32768, -1, -1, 1,
                                 '{16'sh8000, 16'sh8000, 1, 0}));
        table_rows.push_back(row(OP_SUB, -32768, 32767, 1, -1, 1,
                                 '{16'sh8000, 16'sh7FFF, 1, 0}));
        table_rows.push_back(row(OP_SUB, 32767, 0, 32767, 0, 1, '{0, 0, 0, 0}));
        table_rows.push_back(row(OP_MUL, 256, 0, 256, 0, 1, '{256, 0, 0, 0}));
        table_rows.push_back(row(OP_MUL, 0, 256, 0, 256, 1, '{-256, 0, 0, 0}));
        table_rows.push_back(row(OP_MUL, -32768, -32768, -32768, -32768, 1,
                                 '{0, 16'sh7FFF, 1, 0}));
        table_rows.push_back(row(OP_MUL, 32767, -32768, 32767, 32767));
        table_rows.push_back(row(OP_MUL, -1, 1, 1, 1));
        table_rows.push_back(row(OP_DIV, 1234, -99, 0, 0, 1, '{0, 0, 0, 1}));
        table_rows.push_back(row(OP_DIV, 256, 0, 256, 0, 1, '{256, 0, 0, 0}));
        table_rows.push_back(row(OP_DIV, 32767, 32767, 1, 0, 1,
                                 '{16'sh7FFF, 16'sh7FFF, 1, 0}));
        table_rows.push_back(row(OP_DIV, -32768, 32767, -32768, -32768));
        table_rows.push_back(row(OP_DIV, -1, 0, 3, 0));
        table_rows.push_back(row(OP_DIV, 100, -200, 7, -3));
        table_rows.push_back(row(OP_DIV, -32768, -32768, 0, 1));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_rows[i])
            send_item(table_rows[i], 1);

        rounds = 0;
        for (int n = 0; n < 550; n++)
        begin
            v = row(op_t'($urandom_range(0, 3)), rand_part(), rand_part(), rand_part(),
                    rand_part());
            if (v.op == OP_DIV && $urandom_range(0, 15) == 0)
            begin
                v.br = 0;
                v.bi = 0;
            end
            send_item(v, n < 450);
            // Wait out the pipeline once mid-run.
            if (n == 250)
            begin
                start <= 1'b0;
                while (pending_q.size() != 0)
                    @(posedge clk);
            end
        end
        start <= 1'b0;

        while (pending_q.size() != 0 && rounds < 20 * LAT)
        begin
            @(posedge clk);
            rounds++;
        end
        repeat (LAT) @(posedge clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("PASS complex_arithmetic_unit_top");
        else
            $display("FAIL complex_arithmetic_unit_top");
        $finish;
    end
endmodule

>>> filelist.f
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/complex_arithmetic_unit_top.sv
test/complex_arithmetic_unit_top_tb.sv
